// ===== sv/ssd_pkg.sv =====
`default_nettype none

package ssd_pkg;

   // Number of multiplexed digits on the display
   localparam int DigitCount = 4;

   // Request codes
   localparam logic [1:0] ReqWrite = 2'd0;
   localparam logic [1:0] ReqMode  = 2'd1;
   localparam logic [1:0] ReqTick  = 2'd2;
   localparam logic [1:0] ReqScan  = 2'd3;

   // Colon modes
   localparam logic [2:0] ColonOff       = 3'd0;
   localparam logic [2:0] ColonOn        = 3'd1;
   localparam logic [2:0] ColonSlow      = 3'd2;
   localparam logic [2:0] ColonFast      = 3'd3;
   localparam logic [2:0] ColonSuperfast = 3'd4;

   // Blink on-limits and periods in milliseconds
   localparam logic [15:0] SlowOnLimit      = 16'd500;
   localparam logic [15:0] SlowPeriod       = 16'd1000;
   localparam logic [15:0] FastOnLimit      = 16'd200;
   localparam logic [15:0] FastPeriod       = 16'd400;
   localparam logic [15:0] SuperfastOnLimit = 16'd166;
   localparam logic [15:0] SuperfastPeriod  = 16'd333;

   typedef struct packed {
      logic [1:0] req_type;
      logic [4:0] symbol_first;
      logic [4:0] symbol_second;
      logic [4:0] symbol_third;
      logic [4:0] symbol_fourth;
      logic [2:0] colon_mode_req;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] segments_group_b;
      logic [5:0] segments_group_c;
      logic [1:0] digit_position;
      logic       digit_enable;
      logic       colon_lit;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0] grp_b;
      logic [5:0] grp_c;
   } seg_pattern_type;

   // Segment ROM; codes above 24 show blank
   function automatic seg_pattern_type seg_lookup(input logic [4:0] code);
      seg_pattern_type pat;
      case (code)
         5'd0:    pat = '{3'h5, 6'h36};
         5'd1:    pat = '{3'h4, 6'h02};
         5'd2:    pat = '{3'h3, 6'h26};
         5'd3:    pat = '{3'h7, 6'h06};
         5'd4:    pat = '{3'h6, 6'h12};
         5'd5:    pat = '{3'h7, 6'h14};
         5'd6:    pat = '{3'h7, 6'h34};
         5'd7:    pat = '{3'h4, 6'h06};
         5'd8:    pat = '{3'h7, 6'h36};
         5'd9:    pat = '{3'h7, 6'h16};
         5'd10:   pat = '{3'h0, 6'h00};
         5'd11:   pat = '{3'h1, 6'h30};
         5'd12:   pat = '{3'h3, 6'h34};
         5'd13:   pat = '{3'h7, 6'h22};
         5'd14:   pat = '{3'h7, 6'h30};
         5'd15:   pat = '{3'h2, 6'h34};
         5'd16:   pat = '{3'h6, 6'h36};
         5'd17:   pat = '{3'h1, 6'h34};
         5'd18:   pat = '{3'h6, 6'h32};
         5'd19:   pat = '{3'h2, 6'h20};
         5'd20:   pat = '{3'h7, 6'h20};
         5'd21:   pat = '{3'h6, 6'h20};
         5'd22:   pat = '{3'h2, 6'h36};
         5'd23:   pat = '{3'h2, 6'h00};
         5'd24:   pat = '{3'h3, 6'h30};
         default: pat = '{3'h0, 6'h00};
      endcase
      return pat;
   endfunction

   // Map a logical digit to its physical cathode position
   function automatic logic [1:0] phys_of_logical(input logic [1:0] lg);
      logic [1:0] pos;
      case (lg)
         2'd0:    pos = 2'd3;
         2'd1:    pos = 2'd1;
         2'd2:    pos = 2'd0;
         default: pos = 2'd2;
      endcase
      return pos;
   endfunction

endpackage

`default_nettype wire

// ===== sv/ssd_stream_if.sv =====
`default_nettype none

interface ssd_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/ssd_engine.sv =====
`default_nettype none

module ssd_engine (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     fire,
   input  wire ssd_pkg::req_payload_type item,
   output ssd_pkg::rsp_payload_type      result
);

   logic [4:0]  store_ff [ssd_pkg::DigitCount];
   logic [4:0]  store_in [ssd_pkg::DigitCount];
   logic [1:0]  scan_ff, scan_in;
   logic [15:0] timer_ff, timer_in;
   logic [2:0]  mode_ff, mode_in;
   logic        shown_ff, shown_in;
   logic [15:0] timer_step;
   logic [4:0]  code;
   ssd_pkg::seg_pattern_type pattern;

   assign timer_step = timer_ff + 16'd1;
   assign code       = store_ff[scan_ff];
   assign pattern    = ssd_pkg::seg_lookup(code);

   // Compute next state and the result for the beat in the input register
   always_comb begin
      store_in = store_ff;
      scan_in  = scan_ff;
      timer_in = timer_ff;
      mode_in  = mode_ff;
      shown_in = shown_ff;
      result   = '0;
      case (item.req_type)
         ssd_pkg::ReqWrite: begin
            store_in[3] = item.symbol_first;
            store_in[2] = item.symbol_second;
            store_in[1] = item.symbol_third;
            store_in[0] = item.symbol_fourth;
         end
         ssd_pkg::ReqMode: begin
            if (item.colon_mode_req != mode_ff) begin
               mode_in  = item.colon_mode_req;
               timer_in = '0;
            end
         end
         ssd_pkg::ReqTick: begin
            timer_in = timer_step;
            case (mode_ff)
               ssd_pkg::ColonOff: shown_in = 1'b0;
               ssd_pkg::ColonOn:  shown_in = 1'b1;
               ssd_pkg::ColonSlow: begin
                  shown_in = (timer_step < ssd_pkg::SlowOnLimit);
                  if (timer_step >= ssd_pkg::SlowPeriod) timer_in = '0;
               end
               ssd_pkg::ColonFast: begin
                  shown_in = (timer_step < ssd_pkg::FastOnLimit);
                  if (timer_step >= ssd_pkg::FastPeriod) timer_in = '0;
               end
               ssd_pkg::ColonSuperfast: begin
                  shown_in = (timer_step < ssd_pkg::SuperfastOnLimit);
                  if (timer_step >= ssd_pkg::SuperfastPeriod) timer_in = '0;
               end
               default: shown_in = shown_ff;
            endcase
         end
         default: begin
            result.segments_group_b = pattern.grp_b;
            result.segments_group_c = pattern.grp_c;
            result.digit_position   = ssd_pkg::phys_of_logical(scan_ff);
            result.digit_enable     = 1'b1;
            scan_in                 = scan_ff + 2'd1;
         end
      endcase
      // Scan shows the colon held before it; other requests show the new value
      result.colon_lit = shown_in;
   end

   // Hold display state, advance it on each processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ssd_pkg::DigitCount; i++) store_ff[i] <= '0;
         scan_ff  <= '0;
         timer_ff <= '0;
         mode_ff  <= ssd_pkg::ColonOff;
         shown_ff <= 1'b0;
      end else if (fire) begin
         store_ff <= store_in;
         scan_ff  <= scan_in;
         timer_ff <= timer_in;
         mode_ff  <= mode_in;
         shown_ff <= shown_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/seven_segment_scan_with_colon_blink_core.sv =====
`default_nettype none

// Four-digit multiplexed seven-segment driver with a blinking colon. Every
// request beat (write symbols, set colon mode, millisecond tick, scan next
// digit) yields exactly one response beat, in order. The block takes one beat
// per cycle while the response side is not stalled; a beat passes an input
// register, then the state update and segment ROM lookup, then the response
// register, which presents its response. A stalled response holds its
// register while the input register still takes one more beat. Scan responses
// carry segment groups, the physical digit position and digit_enable; other
// responses report only colon_lit.

module seven_segment_scan_with_colon_blink_core (
   input wire logic     clock,
   input wire logic     reset,
   ssd_stream_if.sink   req,
   ssd_stream_if.source rsp
);

   logic                     in_valid_ff;
   ssd_pkg::req_payload_type in_item_ff;
   logic                     rsp_valid_ff;
   ssd_pkg::rsp_payload_type rsp_item_ff;
   ssd_pkg::rsp_payload_type result;
   logic                     out_open;
   logic                     fire;

   assign out_open  = !rsp_valid_ff || rsp.ready;
   assign fire      = in_valid_ff && out_open;
   assign req.ready = !in_valid_ff || out_open;

   ssd_engine engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .result (result)
   );

   // Hold the input beat until the response register can take its result
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
      if (req.valid && req.ready) begin
         in_item_ff <= req.payload;
      end
   end

   // Load the response register, hold it while the sink stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= in_valid_ff;
      end
      if (fire) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_item_ff;

endmodule

`default_nettype wire

// ===== verif/segment_scan_checker.sv =====
`timescale 1ns / 1ps

module segment_scan_checker (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_ready,
   input  ssd_pkg::req_payload_type req_payload,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_ready,
   input  ssd_pkg::rsp_payload_type rsp_payload,
   output int                       mismatch_count,
   output int                       pending_count,
   output int                       checked_count
);

   // Highest symbol code that has a glyph; anything above shows blank
   localparam logic [4:0] LastGlyph = 5'd24;
   // Physical cathode of logical digit n sits at bits 2n+1:2n
   localparam logic [7:0] PosMap = {2'd2, 2'd0, 2'd1, 2'd3};

   logic [8:0]               glyph_rom [0:24];
   logic [4:0]               symbol_slot [0:3];
   logic [1:0]               next_digit;
   logic [15:0]              blink_ms;
   logic [2:0]               colon_mode_cur;
   logic                     colon_vis;
   ssd_pkg::rsp_payload_type expected_display [$];
   int                       err_total;
   int                       pushed_total;
   int                       popped_total;

   // Fill the glyph table: group b in the top three bits, group c below
   initial begin
      glyph_rom[0]  = {3'h5, 6'h36};
      glyph_rom[1]  = {3'h4, 6'h02};
      glyph_rom[2]  = {3'h3, 6'h26};
      glyph_rom[3]  = {3'h7, 6'h06};
      glyph_rom[4]  = {3'h6, 6'h12};
      glyph_rom[5]  = {3'h7, 6'h14};
      glyph_rom[6]  = {3'h7, 6'h34};
      glyph_rom[7]  = {3'h4, 6'h06};
      glyph_rom[8]  = {3'h7, 6'h36};
      glyph_rom[9]  = {3'h7, 6'h16};
      glyph_rom[10] = {3'h0, 6'h00};
      glyph_rom[11] = {3'h1, 6'h30};
      glyph_rom[12] = {3'h3, 6'h34};
      glyph_rom[13] = {3'h7, 6'h22};
      glyph_rom[14] = {3'h7, 6'h30};
      glyph_rom[15] = {3'h2, 6'h34};
      glyph_rom[16] = {3'h6, 6'h36};
      glyph_rom[17] = {3'h1, 6'h34};
      glyph_rom[18] = {3'h6, 6'h32};
      glyph_rom[19] = {3'h2, 6'h20};
      glyph_rom[20] = {3'h7, 6'h20};
      glyph_rom[21] = {3'h6, 6'h20};
      glyph_rom[22] = {3'h2, 6'h36};
      glyph_rom[23] = {3'h2, 6'h00};
      glyph_rom[24] = {3'h3, 6'h30};
      err_total    = 0;
      pushed_total = 0;
      popped_total = 0;
   end

   // Apply one request beat to the display state and build its response
   task automatic predict_display(input ssd_pkg::req_payload_type beat,
                                  output ssd_pkg::rsp_payload_type want);
      logic [4:0]  code;
      logic [15:0] on_limit;
      logic [15:0] period;
      logic        blinking;
      want     = '0;
      blinking = 1'b0;
      on_limit = '0;
      period   = '0;
      case (beat.req_type)
         ssd_pkg::ReqWrite: begin
            symbol_slot[3] = beat.symbol_first;
            symbol_slot[2] = beat.symbol_second;
            symbol_slot[1] = beat.symbol_third;
            symbol_slot[0] = beat.symbol_fourth;
         end
         ssd_pkg::ReqMode: begin
            // restart the blink timer only on a real mode change
            if (beat.colon_mode_req != colon_mode_cur) begin
               colon_mode_cur = beat.colon_mode_req;
               blink_ms       = '0;
            end
         end
         ssd_pkg::ReqTick: begin
            blink_ms = blink_ms + 16'd1;
            case (colon_mode_cur)
               ssd_pkg::ColonOff: colon_vis = 1'b0;
               ssd_pkg::ColonOn:  colon_vis = 1'b1;
               ssd_pkg::ColonSlow: begin
                  blinking = 1'b1;
                  on_limit = ssd_pkg::SlowOnLimit;
                  period   = ssd_pkg::SlowPeriod;
               end
               ssd_pkg::ColonFast: begin
                  blinking = 1'b1;
                  on_limit = ssd_pkg::FastOnLimit;
                  period   = ssd_pkg::FastPeriod;
               end
               ssd_pkg::ColonSuperfast: begin
                  blinking = 1'b1;
                  on_limit = ssd_pkg::SuperfastOnLimit;
                  period   = ssd_pkg::SuperfastPeriod;
               end
               default: ;
            endcase
            if (blinking) begin
               colon_vis = (blink_ms < on_limit);
               if (blink_ms >= period) blink_ms = '0;
            end
         end
         default: begin
            // scan: light the next logical digit, blank above the last glyph
            code = symbol_slot[next_digit];
            if (code <= LastGlyph) begin
               {want.segments_group_b, want.segments_group_c} = glyph_rom[code];
            end
            want.digit_position = PosMap[{next_digit, 1'b0} +: 2];
            want.digit_enable   = 1'b1;
            next_digit          = next_digit + 2'd1;
         end
      endcase
      want.colon_lit = colon_vis;
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         err_total++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Predict on every request beat, compare on every response beat
   always @(posedge clock) begin : watch
      ssd_pkg::rsp_payload_type want;
      if (reset) begin
         for (int i = 0; i < ssd_pkg::DigitCount; i++) symbol_slot[i] = '0;
         next_digit     = '0;
         blink_ms       = '0;
         colon_mode_cur = ssd_pkg::ColonOff;
         colon_vis      = 1'b0;
         expected_display.delete();
         pushed_total = 0;
         popped_total = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_display.size() == 0) begin
               err_total++;
               $display("%0t: response beat with none expected, expected none, actual %h",
                        $time, rsp_payload);
            end else begin
               want = expected_display.pop_front();
               popped_total++;
               compare_field("segments_group_b", want.segments_group_b,
                             rsp_payload.segments_group_b);
               compare_field("segments_group_c", want.segments_group_c,
                             rsp_payload.segments_group_c);
               compare_field("digit_position", want.digit_position,
                             rsp_payload.digit_position);
               compare_field("digit_enable", want.digit_enable, rsp_payload.digit_enable);
               compare_field("colon_lit", want.colon_lit, rsp_payload.colon_lit);
            end
         end
         if (req_valid && req_ready) begin
            predict_display(req_payload, want);
            expected_display.push_back(want);
            pushed_total++;
         end
      end
      mismatch_count <= err_total;
      pending_count  <= pushed_total - popped_total;
      checked_count  <= popped_total;
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   // Mode code with no blink behavior of its own
   localparam logic [2:0] ColonUnused = 3'd7;

   logic clock;
   logic reset;
   logic calm;
   int   mismatches;
   int   pending;
   int   checked;
   int   kind_count [0:3];
   int   random_sent;

   ssd_stream_if #(.payload_type(ssd_pkg::req_payload_type)) req_if ();
   ssd_stream_if #(.payload_type(ssd_pkg::rsp_payload_type)) rsp_if ();

   seven_segment_scan_with_colon_blink_core u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   segment_scan_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_payload    (req_if.payload),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_payload    (rsp_if.payload),
      .mismatch_count (mismatches),
      .pending_count  (pending),
      .checked_count  (checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("testbench failed");
      $finish;
   end

   // Stall the response side at random, except in the calm stretch
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= calm || ($urandom_range(99) >= 22);
      end
   end

   // Random request of the given kind; fields it ignores get noise
   function automatic ssd_pkg::req_payload_type scramble(input logic [1:0] kind);
      ssd_pkg::req_payload_type p;
      p.req_type       = kind;
      p.symbol_first   = 5'($urandom_range(31));
      p.symbol_second  = 5'($urandom_range(31));
      p.symbol_third   = 5'($urandom_range(31));
      p.symbol_fourth  = 5'($urandom_range(31));
      p.colon_mode_req = 3'($urandom_range(7));
      return p;
   endfunction

   // Hold the beat until accepted, idling before it at random
   task automatic send_beat(input ssd_pkg::req_payload_type beat);
      while (!calm && $urandom_range(99) < 22) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= beat;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      kind_count[beat.req_type]++;
   endtask

   task automatic send_kind(input logic [1:0] kind);
      send_beat(scramble(kind));
   endtask

   task automatic send_write(input logic [4:0] a, b, c, d);
      ssd_pkg::req_payload_type p;
      p               = scramble(ssd_pkg::ReqWrite);
      p.symbol_first  = a;
      p.symbol_second = b;
      p.symbol_third  = c;
      p.symbol_fourth = d;
      send_beat(p);
   endtask

   task automatic send_mode(input logic [2:0] mode);
      ssd_pkg::req_payload_type p;
      p                = scramble(ssd_pkg::ReqMode);
      p.colon_mode_req = mode;
      send_beat(p);
   endtask

   // Enter a colon mode, then mostly ticks with scans, writes and noise mixed in
   task automatic run_phase(input logic [2:0] mode, input int span, input int tick_pct);
      int pick;
      send_mode(mode);
      random_sent++;
      for (int i = 0; i < span; i++) begin
         calm <= (random_sent >= 900 && random_sent < 1100);
         if ($urandom_range(99) < tick_pct) begin
            send_kind(ssd_pkg::ReqTick);
         end else begin
            pick = $urandom_range(19);
            if (pick <= 10) send_kind(ssd_pkg::ReqScan);
            else if (pick <= 15) send_kind(ssd_pkg::ReqWrite);
            else if (pick <= 17) send_mode(mode);
            else send_beat(scramble(2'($urandom_range(3))));
         end
         random_sent++;
      end
   endtask

   initial begin
      logic [2:0] mode;
      int         span;
      int         tick_pct;
      reset          <= 1'b1;
      calm           <= 1'b0;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      random_sent = 0;
      for (int i = 0; i < 4; i++) kind_count[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // scan the cleared store, then blank codes and the last glyph
      repeat (4) send_kind(ssd_pkg::ReqScan);
      send_write(5'd31, 5'd24, 5'd25, 5'd0);
      repeat (4) send_kind(ssd_pkg::ReqScan);
      // steady colon, repeated mode, unused mode code
      send_mode(ssd_pkg::ColonOn);
      send_kind(ssd_pkg::ReqTick);
      send_kind(ssd_pkg::ReqScan);
      send_mode(ssd_pkg::ColonOn);
      send_kind(ssd_pkg::ReqTick);
      send_mode(ColonUnused);
      send_kind(ssd_pkg::ReqTick);
      // first tick of every blink mode, then back to off
      send_mode(ssd_pkg::ColonSuperfast);
      send_kind(ssd_pkg::ReqTick);
      send_mode(ssd_pkg::ColonFast);
      send_kind(ssd_pkg::ReqTick);
      send_mode(ssd_pkg::ColonSlow);
      send_kind(ssd_pkg::ReqTick);
      send_mode(ssd_pkg::ColonOff);
      send_kind(ssd_pkg::ReqTick);

      // one long slow phase to pass its on-limit and its period
      run_phase(ssd_pkg::ColonSlow, 1060, 96);
      while (random_sent < 1200) begin
         if ($urandom_range(99) < 60) begin
            mode = 3'($urandom_range(ssd_pkg::ColonSuperfast, ssd_pkg::ColonSlow));
         end else begin
            mode = 3'($urandom_range(7));
         end
         tick_pct = 85;
         case (mode)
            ssd_pkg::ColonSlow:      span = $urandom_range(400, 150);
            ssd_pkg::ColonFast:      span = $urandom_range(500, 150);
            ssd_pkg::ColonSuperfast: span = $urandom_range(450, 150);
            default: begin
               span     = $urandom_range(60, 20);
               tick_pct = 50;
            end
         endcase
         run_phase(mode, span, tick_pct);
      end
      req_if.valid <= 1'b0;

      // drain outstanding responses
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d writes, %0d colon mode requests, %0d ticks, %0d scans",
               kind_count[ssd_pkg::ReqWrite], kind_count[ssd_pkg::ReqMode],
               kind_count[ssd_pkg::ReqTick], kind_count[ssd_pkg::ReqScan]);
      $display("%0d response beats checked, %0d mismatches", checked, mismatches);
      if (mismatches == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
